@@ rtl/tare_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tare_pkg: shared types and constants of the alarm rule engine
// Rule table geometry, field codes, the stored rule word and the evaluator
// result that passes from the rule evaluator to the sweep control.
// ----------------------------------------------------------------------------
package tare_pkg;

  localparam int unsigned RULE_COUNT = 16;
  localparam int unsigned IDX_W      = $clog2(RULE_COUNT);
  localparam int unsigned CNT_W      = $clog2(RULE_COUNT + 1);

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    CMP_GT    = 3'd0,
    CMP_LT    = 3'd1,
    CMP_EQ    = 3'd2,
    CMP_LE    = 3'd3,
    CMP_GE    = 3'd4,
    CMP_NE    = 3'd5,
    CMP_STUCK = 3'd6
  } compare_e;

  typedef enum logic [1:0] {
    LINK_NONE = 2'd0,
    LINK_OR   = 2'd1,
    LINK_AND  = 2'd2
  } link_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FLUSH
  } state_e;

  // One rule as held in the table memory
  typedef struct packed {
    logic [7:0]         source;
    logic [2:0]         compare;
    logic [1:0]         link;
    logic [3:0]         partner;
    logic [7:0]         severity;
    logic [4:0]         channel;
    logic signed [63:0] reference;
    logic [31:0]        hold;
    logic [31:0]        changed_at;
  } rule_t;

  // Outcome of evaluating one rule against the current sample
  typedef struct packed {
    logic       fired;     // new fired flag
    logic       wr_en;     // entry needs writing back (stuck re-latch)
    rule_t      entry;     // entry to write back
    logic       ev_vld;    // an event word is due
    logic [7:0] severity;  // severity of that event, 0 for a clear
  } eval_res_t;

endpackage

@@ rtl/tare_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tare_in_if: input channel of the alarm rule engine
// Valid/ready channel carrying rule loads and samples.
// ----------------------------------------------------------------------------
interface tare_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [7:0]         source_id;
  logic signed [63:0] sample_value;
  logic [31:0]        now_seconds;
  logic [3:0]         rule_slot;
  logic [2:0]         rule_compare;
  logic [1:0]         rule_link;
  logic [3:0]         rule_partner;
  logic [7:0]         rule_severity;
  logic [4:0]         rule_channel;
  logic signed [63:0] rule_reference;
  logic [31:0]        rule_hold;

  modport source (
    output valid, action, source_id, sample_value, now_seconds, rule_slot,
           rule_compare, rule_link, rule_partner, rule_severity, rule_channel,
           rule_reference, rule_hold,
    input  ready
  );

  modport sink (
    input  valid, action, source_id, sample_value, now_seconds, rule_slot,
           rule_compare, rule_link, rule_partner, rule_severity, rule_channel,
           rule_reference, rule_hold,
    output ready
  );
endinterface

@@ rtl/tare_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tare_out_if: event channel of the alarm rule engine
// Valid/ready channel carrying alarm raise and clear events.
// ----------------------------------------------------------------------------
interface tare_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_rule;
  logic [7:0] event_severity;
  logic [4:0] event_channel;
  logic       last_event;

  modport source (
    output valid, event_rule, event_severity, event_channel, last_event,
    input  ready
  );

  modport sink (
    input  valid, event_rule, event_severity, event_channel, last_event,
    output ready
  );
endinterface

@@ rtl/tare_rule_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tare_rule_eval: single rule evaluator
// Compares a sample against one rule, applies the partner link and works
// out the new fired flag, the stuck re-latch and any event due.
// ----------------------------------------------------------------------------
module tare_rule_eval (
  input  tare_pkg::rule_t     entry_i,
  input  logic                valid_i,
  input  logic                fired_i,
  input  logic                partner_fired_i,
  input  logic [7:0]          src_i,
  input  logic signed [63:0]  value_i,
  input  logic [31:0]         now_i,
  output tare_pkg::eval_res_t res_o
);
  import tare_pkg::*;

  logic        match;
  logic        differs;
  logic        cmp_hit;
  logic        hit;
  logic        stuck;
  logic [31:0] age;

  assign match   = valid_i && (entry_i.source == src_i);
  assign differs = (value_i != entry_i.reference);
  assign stuck   = (entry_i.compare == CMP_STUCK);
  assign age     = now_i - entry_i.changed_at;

  always_comb begin
    case (entry_i.compare)
      CMP_GT:    cmp_hit = value_i >  entry_i.reference;
      CMP_LT:    cmp_hit = value_i <  entry_i.reference;
      CMP_EQ:    cmp_hit = !differs;
      CMP_LE:    cmp_hit = value_i <= entry_i.reference;
      CMP_GE:    cmp_hit = value_i >= entry_i.reference;
      CMP_NE:    cmp_hit = differs;
      CMP_STUCK: cmp_hit = !differs && (age > entry_i.hold);
      default:   cmp_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (entry_i.link)
      LINK_OR:  hit = cmp_hit || partner_fired_i;
      LINK_AND: hit = cmp_hit && partner_fired_i;
      default:  hit = cmp_hit;
    endcase
  end

  always_comb begin
    res_o          = '0;
    res_o.fired    = match ? hit : fired_i;
    res_o.wr_en    = match && stuck && differs;
    res_o.entry    = entry_i;
    res_o.entry.reference  = value_i;
    res_o.entry.changed_at = now_i;
    res_o.ev_vld   = match && ((hit && !fired_i && (entry_i.severity != 8'd0)) ||
                               (!hit && fired_i));
    res_o.severity = hit ? entry_i.severity : 8'd0;
  end

endmodule

@@ rtl/threshold_alarm_rule_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_alarm_rule_engine: table driven threshold alarm engine
// Holds 16 alarm rules in a single-port-read table memory and sweeps them
// for every sample, emitting raise and clear events.
// ----------------------------------------------------------------------------
// Usage
//   in_i carries one word per load or sample. A load (action 0) writes a rule
//   into its slot, sets it valid and clears its fired flag.
//   A sample (action 1) starts a sweep over all slots in index order; each
//   valid rule whose source matches is evaluated against the sample, and its
//   partner flag is taken as it stands at that point of the sweep.
//   out_o words are the events of the sweep, in rule order; the last word of
//   a sample carries last_event. A sample with no state change yields none.
// Timing
//   A load is written into the table when it is accepted. A sample is
//   accepted, then swept one slot per cycle behind the registered table
//   read while out_o does not stall, then flushed. The table read port,
//   one slot a cycle, sets that rate.
//   in_i.ready is high only between items.
// Reset
//   Clears all valid and fired flags and empties the event path. Table
//   contents are not cleared; unused slots are never evaluated.
// Back-pressure
//   The newest event waits in a holding register until it is known whether
//   another follows; when a new event meets out_o stalled with both registers
//   full, the sweep holds on its current slot until a word drains.
// ----------------------------------------------------------------------------
module threshold_alarm_rule_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  tare_in_if.sink     in_i,
  tare_out_if.source  out_o
);
  import tare_pkg::*;

  // Rule table memory
  rule_t              rule_mem [RULE_COUNT];
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  rule_t              mem_wdata;
  rule_t              rd_data_q;

  // Sweep control
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0]   ev_idx_q, ev_idx_d;
  logic [RULE_COUNT-1:0] valid_q, valid_d;
  logic [RULE_COUNT-1:0] fired_q, fired_d;

  // Latched sample
  logic [7:0]         smp_src_q;
  logic signed [63:0] smp_val_q;
  logic [31:0]        smp_now_q;

  // Holding register for the newest event
  logic               pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]   pend_rule_q, pend_rule_d;
  logic [7:0]         pend_sev_q, pend_sev_d;
  logic [4:0]         pend_chan_q, pend_chan_d;

  // Output register
  logic               out_vld_q, out_vld_d;
  logic [IDX_W-1:0]   out_rule_q, out_rule_d;
  logic [7:0]         out_sev_q, out_sev_d;
  logic [4:0]         out_chan_q, out_chan_d;
  logic               out_last_q, out_last_d;

  logic               in_fire;
  logic               is_sample;
  logic               load;
  logic               sweep_done;
  logic               out_free;
  logic               stall;
  logic               step;
  logic               eval_now;
  logic               emit;
  logic               partner_fired;
  eval_res_t          res;

  assign in_fire    = in_i.valid && in_i.ready;
  assign is_sample  = (in_i.action == ACT_SAMPLE);
  assign load       = in_fire && !is_sample && (32'(in_i.rule_slot) < RULE_COUNT);
  assign sweep_done = (rd_idx_q == CNT_W'(RULE_COUNT));
  assign out_free   = !out_vld_q || out_o.ready;

  // Partner flag as it stands now; an index beyond the table reads as clear
  assign partner_fired = (32'(rd_data_q.partner) < RULE_COUNT) &&
                         fired_q[rd_data_q.partner[IDX_W-1:0]];

  tare_rule_eval u_eval (
    .entry_i         (rd_data_q),
    .valid_i         (valid_q[ev_idx_q]),
    .fired_i         (fired_q[ev_idx_q]),
    .partner_fired_i (partner_fired),
    .src_i           (smp_src_q),
    .value_i         (smp_val_q),
    .now_i           (smp_now_q),
    .res_o           (res)
  );

  // Hold the sweep when a new event meets a full holding and output pair
  assign stall    = ev_vld_q && res.ev_vld && pend_vld_q && !out_free;
  assign step     = (state_q == ST_SWEEP) && !stall;
  assign eval_now = step && ev_vld_q;
  assign emit     = eval_now && res.ev_vld;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire && is_sample) state_d = ST_SWEEP;
      ST_SWEEP: if (step && sweep_done && !ev_vld_q) state_d = ST_FLUSH;
      ST_FLUSH: if (!pend_vld_q || out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State-derived outputs
  always_comb begin
    in_i.ready = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_i.ready = 1'b1;
      ST_SWEEP: in_i.ready = 1'b0;
      ST_FLUSH: in_i.ready = 1'b0;
      default:  in_i.ready = 1'b0;
    endcase
  end

  // Table access: read the next slot, write back the evaluated one or a load
  always_comb begin
    mem_re    = step && !sweep_done;
    mem_raddr = rd_idx_q[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = ev_idx_q;
    mem_wdata = res.entry;
    if (load) begin
      mem_we               = 1'b1;
      mem_waddr            = in_i.rule_slot[IDX_W-1:0];
      mem_wdata.source     = in_i.source_id;
      mem_wdata.compare    = in_i.rule_compare;
      mem_wdata.link       = in_i.rule_link;
      mem_wdata.partner    = in_i.rule_partner;
      mem_wdata.severity   = in_i.rule_severity;
      mem_wdata.channel    = in_i.rule_channel;
      mem_wdata.reference  = in_i.rule_reference;
      mem_wdata.hold       = in_i.rule_hold;
      mem_wdata.changed_at = in_i.now_seconds;
    end else if (eval_now && res.wr_en) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rule_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= rule_mem[mem_raddr];
    end
  end

  // Sweep pointers and rule flags
  always_comb begin
    rd_idx_d = rd_idx_q;
    ev_vld_d = ev_vld_q;
    ev_idx_d = ev_idx_q;
    valid_d  = valid_q;
    fired_d  = fired_q;
    if (in_fire && is_sample) begin
      rd_idx_d = '0;
      ev_vld_d = 1'b0;
    end
    if (step) begin
      ev_vld_d = !sweep_done;
      ev_idx_d = rd_idx_q[IDX_W-1:0];
      if (!sweep_done) begin
        rd_idx_d = rd_idx_q + CNT_W'(1);
      end
    end
    if (eval_now) begin
      fired_d[ev_idx_q] = res.fired;
    end
    if (load) begin
      valid_d[in_i.rule_slot[IDX_W-1:0]] = 1'b1;
      fired_d[in_i.rule_slot[IDX_W-1:0]] = 1'b0;
    end
  end

  // Event path: push the held word out once another arrives or the sweep ends
  always_comb begin
    pend_vld_d  = pend_vld_q;
    pend_rule_d = pend_rule_q;
    pend_sev_d  = pend_sev_q;
    pend_chan_d = pend_chan_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_rule_d  = out_rule_q;
    out_sev_d   = out_sev_q;
    out_chan_d  = out_chan_q;
    out_last_d  = out_last_q;
    if (emit) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_rule_d = pend_rule_q;
        out_sev_d  = pend_sev_q;
        out_chan_d = pend_chan_q;
        out_last_d = 1'b0;
      end
      pend_vld_d  = 1'b1;
      pend_rule_d = ev_idx_q;
      pend_sev_d  = res.severity;
      pend_chan_d = rd_data_q.channel;
    end
    if ((state_q == ST_FLUSH) && pend_vld_q && out_free) begin
      out_vld_d  = 1'b1;
      out_rule_d = pend_rule_q;
      out_sev_d  = pend_sev_q;
      out_chan_d = pend_chan_q;
      out_last_d = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_idx_q   <= '0;
      ev_vld_q   <= 1'b0;
      valid_q    <= '0;
      fired_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      ev_vld_q   <= ev_vld_d;
      valid_q    <= valid_d;
      fired_q    <= fired_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ev_idx_q    <= ev_idx_d;
    pend_rule_q <= pend_rule_d;
    pend_sev_q  <= pend_sev_d;
    pend_chan_q <= pend_chan_d;
    out_rule_q  <= out_rule_d;
    out_sev_q   <= out_sev_d;
    out_chan_q  <= out_chan_d;
    out_last_q  <= out_last_d;
    if (in_fire && is_sample) begin
      smp_src_q <= in_i.source_id;
      smp_val_q <= in_i.sample_value;
      smp_now_q <= in_i.now_seconds;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.event_rule     = out_rule_q;
  assign out_o.event_severity = out_sev_q;
  assign out_o.event_channel  = out_chan_q;
  assign out_o.last_event     = out_last_q;

endmodule
